@@ hw/rtl/i2cw_pkg.sv @@
`default_nettype none

package i2cw_pkg;

  // Reset value of the acknowledge timeout register
  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd10;
  // Cleared bit 0 of an address byte marks a write
  localparam logic [7:0] ADDR_WRITE_MASK   = 8'hfe;
  // Saturation value of the acknowledge wait counter
  localparam logic [7:0] WAIT_MAX          = 8'hff;
  // Number of data bits in one byte
  localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

  // Input item operations
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HOLD,
    PH_START1,
    PH_START2,
    PH_START3,
    PH_BIT_LOW,
    PH_BIT_HIGH,
    PH_ACK_LOW,
    PH_ACK_POLL,
    PH_ACK_END,
    PH_STOP1,
    PH_STOP2
  } phase_t;

  // One result item
  typedef struct packed {
    logic scl;
    logic sda_out;
    logic ready_res;
    logic ack_valid;
    logic ack_ok;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/i2cw_if.sv @@
`default_nettype none

// Input item channel
interface i2cw_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data;
  logic       first;
  logic       last;
  logic       sda_in;

  modport source (output valid, output op, output data, output first, output last,
                  output sda_in, input ready);
  modport sink   (input valid, input op, input data, input first, input last,
                  input sda_in, output ready);
endinterface

// Result item channel
interface i2cw_out_if;
  logic valid;
  logic ready;
  logic scl;
  logic sda_out;
  logic ready_res;
  logic ack_valid;
  logic ack_ok;

  modport source (output valid, output scl, output sda_out, output ready_res,
                  output ack_valid, output ack_ok, input ready);
  modport sink   (input valid, input scl, input sda_out, input ready_res,
                  input ack_valid, input ack_ok, output ready);
endinterface

// Configuration write channel (acknowledge timeout register)
interface i2cw_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/i2cw_seq.sv @@
`default_nettype none

module i2cw_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [7:0]      cfg_data,
  input  wire logic            accept,
  input  wire logic            op,
  input  wire logic [7:0]      data,
  input  wire logic            first,
  input  wire logic            last,
  input  wire logic            sda_in,
  output i2cw_pkg::res_t       res
);

  i2cw_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [3:0] bit_idx_r, bit_idx_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic       stop_r, stop_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic [7:0] timeout_r;
  logic       ack_valid, ack_ok;
  logic [7:0] wait_inc;
  logic       timed_out;
  logic       ready_now;
  logic       cur_bit;

  assign ready_now = (phase_r == i2cw_pkg::PH_IDLE) || (phase_r == i2cw_pkg::PH_HOLD);
  assign wait_inc  = (wait_r == i2cw_pkg::WAIT_MAX) ? wait_r : wait_r + 8'd1;
  assign timed_out = (wait_inc >= timeout_r);
  assign cur_bit   = shift_r[3'd7 - bit_idx_r[2:0]];

  // Next state of the bus sequencer
  always_comb begin
    phase_nxt   = phase_r;
    shift_nxt   = shift_r;
    bit_idx_nxt = bit_idx_r;
    wait_nxt    = wait_r;
    stop_nxt    = stop_r;
    if (op == i2cw_pkg::OP_LOAD) begin
      if (ready_now) begin
        shift_nxt   = first ? (data & i2cw_pkg::ADDR_WRITE_MASK) : data;
        stop_nxt    = last;
        bit_idx_nxt = '0;
        wait_nxt    = '0;
        phase_nxt   = first ? i2cw_pkg::PH_START1 : i2cw_pkg::PH_BIT_LOW;
      end
    end else begin
      unique case (phase_r)
        i2cw_pkg::PH_START1:  phase_nxt = i2cw_pkg::PH_START2;
        i2cw_pkg::PH_START2:  phase_nxt = i2cw_pkg::PH_START3;
        i2cw_pkg::PH_START3:  phase_nxt = i2cw_pkg::PH_BIT_LOW;
        i2cw_pkg::PH_BIT_LOW: phase_nxt = i2cw_pkg::PH_BIT_HIGH;
        i2cw_pkg::PH_BIT_HIGH: begin
          bit_idx_nxt = bit_idx_r + 4'd1;
          phase_nxt   = (bit_idx_nxt >= i2cw_pkg::BITS_PER_BYTE) ?
                        i2cw_pkg::PH_ACK_LOW : i2cw_pkg::PH_BIT_LOW;
        end
        i2cw_pkg::PH_ACK_LOW: begin
          wait_nxt  = '0;
          phase_nxt = i2cw_pkg::PH_ACK_POLL;
        end
        i2cw_pkg::PH_ACK_POLL: begin
          if (!sda_in) begin
            phase_nxt = i2cw_pkg::PH_ACK_END;
          end else begin
            wait_nxt = wait_inc;
            if (timed_out) phase_nxt = i2cw_pkg::PH_ACK_END;
          end
        end
        i2cw_pkg::PH_ACK_END:
          phase_nxt = stop_r ? i2cw_pkg::PH_STOP1 : i2cw_pkg::PH_HOLD;
        i2cw_pkg::PH_STOP1:   phase_nxt = i2cw_pkg::PH_STOP2;
        i2cw_pkg::PH_STOP2: begin
          stop_nxt  = 1'b0;
          phase_nxt = i2cw_pkg::PH_IDLE;
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Line levels and acknowledge status of this item
  always_comb begin
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_valid = 1'b0;
    ack_ok    = 1'b0;
    if (op == i2cw_pkg::OP_TICK) begin
      unique case (phase_r)
        i2cw_pkg::PH_START1:   begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
        i2cw_pkg::PH_START2:   begin scl_nxt = 1'b1; sda_nxt = 1'b0; end
        i2cw_pkg::PH_START3:   begin scl_nxt = 1'b0; sda_nxt = 1'b0; end
        i2cw_pkg::PH_BIT_LOW:  begin scl_nxt = 1'b0; sda_nxt = cur_bit; end
        i2cw_pkg::PH_BIT_HIGH: scl_nxt = 1'b1;
        i2cw_pkg::PH_ACK_LOW:  begin scl_nxt = 1'b0; sda_nxt = 1'b1; end
        i2cw_pkg::PH_ACK_POLL: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
          if (!sda_in) begin
            ack_valid = 1'b1;
            ack_ok    = 1'b1;
          end else if (timed_out) begin
            ack_valid = 1'b1;
          end
        end
        i2cw_pkg::PH_ACK_END:  begin scl_nxt = 1'b0; sda_nxt = !stop_r; end
        i2cw_pkg::PH_STOP1:    begin scl_nxt = 1'b1; sda_nxt = 1'b0; end
        i2cw_pkg::PH_STOP2:    begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
        default: begin
          scl_nxt = scl_r;
          sda_nxt = sda_r;
        end
      endcase
    end
  end

  always_comb begin
    res.scl       = scl_nxt;
    res.sda_out   = sda_nxt;
    res.ready_res = (phase_nxt == i2cw_pkg::PH_IDLE) || (phase_nxt == i2cw_pkg::PH_HOLD);
    res.ack_valid = ack_valid;
    res.ack_ok    = ack_ok;
  end

  // Sequencer registers, advanced once per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= i2cw_pkg::PH_IDLE;
      shift_r   <= '0;
      bit_idx_r <= '0;
      wait_r    <= '0;
      stop_r    <= 1'b0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      timeout_r <= i2cw_pkg::ACK_TIMEOUT_RESET;
    end else begin
      if (cfg_we) timeout_r <= cfg_data;
      if (accept) begin
        phase_r   <= phase_nxt;
        shift_r   <= shift_nxt;
        bit_idx_r <= bit_idx_nxt;
        wait_r    <= wait_nxt;
        stop_r    <= stop_nxt;
        scl_r     <= scl_nxt;
        sda_r     <= sda_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/i2cw_out_buf.sv @@
`default_nettype none

module i2cw_out_buf (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire i2cw_pkg::res_t  in_res,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output i2cw_pkg::res_t       out_res
);

  logic           out_valid_r;
  logic           skid_valid_r;
  i2cw_pkg::res_t out_res_r;
  i2cw_pkg::res_t skid_res_r;
  logic           push;
  logic           out_busy;

  assign in_ready  = !skid_valid_r;
  assign push      = in_valid && in_ready;
  assign out_busy  = out_valid_r && !out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_ready) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (push) begin
        if (out_busy) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload moves without reset
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) out_res_r <= skid_res_r;
    end else if (push) begin
      if (out_busy) begin
        skid_res_r <= in_res;
      end else begin
        out_res_r <= in_res;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/i2c_master_byte_writer.sv @@
`default_nettype none

// Transmit-only I2C master for write transactions, paced by tick items: each
// tick transaction advances the bus at most one phase, and each load transaction
// hands over a byte while the bus is free (first = address byte with start and
// bit 0 cleared, last = stop after the acknowledge). Every input transaction
// yields exactly one result with the driven SCL/SDA levels, a ready flag for
// the next load, and the acknowledge status on the tick that decides it. The
// sequencer state advances at the accepting edge and the result is captured in
// an output register, with a one-entry skid stage so a new item can be taken
// while a result still waits. The acknowledge timeout register must be written
// by the user through the cfg channel while idle; the block does not enforce it.
module i2c_master_byte_writer (
  input  wire logic clk,
  input  wire logic rst_n,
  i2cw_in_if.sink   in_ch,
  i2cw_out_if.source out_ch,
  i2cw_cfg_if.sink  cfg_ch
);

  i2cw_pkg::res_t seq_res;
  i2cw_pkg::res_t buf_res;
  logic           in_ready;
  logic           accept;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;
  assign accept       = in_ch.valid && in_ready;

  // Bus sequencer
  i2cw_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_ch.valid),
    .cfg_data (cfg_ch.data),
    .accept   (accept),
    .op       (in_ch.op),
    .data     (in_ch.data),
    .first    (in_ch.first),
    .last     (in_ch.last),
    .sda_in   (in_ch.sda_in),
    .res      (seq_res)
  );

  // Result register and skid stage
  i2cw_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_res    (seq_res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (buf_res)
  );

  assign out_ch.scl       = buf_res.scl;
  assign out_ch.sda_out   = buf_res.sda_out;
  assign out_ch.ready_res = buf_res.ready_res;
  assign out_ch.ack_valid = buf_res.ack_valid;
  assign out_ch.ack_ok    = buf_res.ack_ok;

endmodule

`default_nettype wire

@@ tb/sv/tb_i2c_master_byte_writer.sv @@
`timescale 1ns / 100ps

module tb_i2c_master_byte_writer;

  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 1050;

  logic clk;
  logic rst_n;

  i2cw_in_if  in_bus ();
  i2cw_out_if out_bus ();
  i2cw_cfg_if cfg_bus ();

  i2c_master_byte_writer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Bus sequencer mirror
  i2cw_pkg::phase_t m_phase;
  logic [7:0]       m_shift;
  logic [3:0]       m_bit_idx;
  logic [7:0]       m_wait;
  logic             m_stop;
  logic             m_scl;
  logic             m_sda;
  logic [7:0]       m_timeout;

  i2cw_pkg::res_t expected_levels[$];

  int errors;
  int useful_items;
  int cycles;
  int src_idle_pct;
  int sink_idle_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_levels.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result sink stalls
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  function automatic bit bus_free();
    return (m_phase == i2cw_pkg::PH_IDLE || m_phase == i2cw_pkg::PH_HOLD);
  endfunction

  // Advance the mirror by one item and return the line levels and status it gives
  function automatic i2cw_pkg::res_t advance_bus(logic op, logic [7:0] data, logic first,
                                                 logic last, logic sda_in);
    i2cw_pkg::res_t r;
    logic [2:0]     sel;
    r = '0;
    if (op == i2cw_pkg::OP_LOAD) begin
      // load is ignored while busy
      if (bus_free()) begin
        m_shift   = first ? (data & i2cw_pkg::ADDR_WRITE_MASK) : data;
        m_stop    = last;
        m_bit_idx = '0;
        m_wait    = '0;
        m_phase   = first ? i2cw_pkg::PH_START1 : i2cw_pkg::PH_BIT_LOW;
      end
    end else begin
      case (m_phase)
        i2cw_pkg::PH_START1: begin
          m_scl = 1'b1; m_sda = 1'b1; m_phase = i2cw_pkg::PH_START2;
        end
        i2cw_pkg::PH_START2: begin
          m_scl = 1'b1; m_sda = 1'b0; m_phase = i2cw_pkg::PH_START3;
        end
        i2cw_pkg::PH_START3: begin
          m_scl = 1'b0; m_sda = 1'b0; m_phase = i2cw_pkg::PH_BIT_LOW;
        end
        i2cw_pkg::PH_BIT_LOW: begin
          sel = 3'd7 - m_bit_idx[2:0];
          m_scl = 1'b0; m_sda = m_shift[sel]; m_phase = i2cw_pkg::PH_BIT_HIGH;
        end
        i2cw_pkg::PH_BIT_HIGH: begin
          m_scl = 1'b1;
          m_bit_idx = m_bit_idx + 4'd1;
          m_phase = (m_bit_idx >= i2cw_pkg::BITS_PER_BYTE) ?
                    i2cw_pkg::PH_ACK_LOW : i2cw_pkg::PH_BIT_LOW;
        end
        i2cw_pkg::PH_ACK_LOW: begin
          m_scl = 1'b0; m_sda = 1'b1; m_wait = '0; m_phase = i2cw_pkg::PH_ACK_POLL;
        end
        i2cw_pkg::PH_ACK_POLL: begin
          m_scl = 1'b1; m_sda = 1'b1;
          if (!sda_in) begin
            r.ack_valid = 1'b1;
            r.ack_ok    = 1'b1;
            m_phase     = i2cw_pkg::PH_ACK_END;
          end else begin
            // counter saturates; a zero timeout acts like one
            if (m_wait < i2cw_pkg::WAIT_MAX) m_wait = m_wait + 8'd1;
            if (m_wait >= m_timeout) begin
              r.ack_valid = 1'b1;
              m_phase     = i2cw_pkg::PH_ACK_END;
            end
          end
        end
        i2cw_pkg::PH_ACK_END: begin
          if (m_stop) begin
            m_scl = 1'b0; m_sda = 1'b0; m_phase = i2cw_pkg::PH_STOP1;
          end else begin
            m_scl = 1'b0; m_sda = 1'b1; m_phase = i2cw_pkg::PH_HOLD;
          end
        end
        i2cw_pkg::PH_STOP1: begin
          m_scl = 1'b1; m_sda = 1'b0; m_phase = i2cw_pkg::PH_STOP2;
        end
        i2cw_pkg::PH_STOP2: begin
          m_scl = 1'b1; m_sda = 1'b1; m_stop = 1'b0; m_phase = i2cw_pkg::PH_IDLE;
        end
        default: ;
      endcase
    end
    r.scl       = m_scl;
    r.sda_out   = m_sda;
    r.ready_res = bus_free();
    return r;
  endfunction

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %b, actual %b", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    i2cw_pkg::res_t want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual scl=%b sda=%b rdy=%b av=%b ok=%b",
                 $time, out_bus.scl, out_bus.sda_out, out_bus.ready_res,
                 out_bus.ack_valid, out_bus.ack_ok);
        errors++;
      end else begin
        want = expected_levels.pop_front();
        check_field("scl", want.scl, out_bus.scl);
        check_field("sda_out", want.sda_out, out_bus.sda_out);
        check_field("ready_res", want.ready_res, out_bus.ready_res);
        check_field("ack_valid", want.ack_valid, out_bus.ack_valid);
        check_field("ack_ok", want.ack_ok, out_bus.ack_ok);
      end
    end
  end

  // Send one input transaction; entered and left just after a falling edge
  task automatic send_item(input logic op, input logic [7:0] data, input logic first,
                           input logic last, input logic sda_in);
    bit useful;
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid  = 1'b1;
    in_bus.op     = op;
    in_bus.data   = data;
    in_bus.first  = first;
    in_bus.last   = last;
    in_bus.sda_in = sda_in;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    useful = (op == i2cw_pkg::OP_LOAD) ? bus_free() : !bus_free();
    if (useful) useful_items++;
    expected_levels.push_back(advance_bus(op, data, first, last, sda_in));
    @(negedge clk);
    // a following send raises valid again in the same time step
    in_bus.valid = 1'b0;
  endtask

  task automatic send_tick(input logic sda_in);
    send_item(i2cw_pkg::OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
              1'($urandom_range(1)), sda_in);
  endtask

  task automatic write_timeout(input logic [7:0] value);
    cfg_bus.valid = 1'b1;
    cfg_bus.data  = value;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    m_timeout = value;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_levels.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // One byte: load it, then tick until the sequencer is free again. The slave
  // pulls SDA low on poll sample ack_delay; a negative delay never acknowledges.
  task automatic run_byte(input logic [7:0] data, input logic first, input logic last,
                          input int ack_delay, input int noise_pct);
    int   polls;
    logic sda;
    send_item(i2cw_pkg::OP_LOAD, data, first, last, 1'($urandom_range(1)));
    polls = 0;
    while (!bus_free()) begin
      if ($urandom_range(99) < noise_pct) begin
        // load while busy, ignored
        send_item(i2cw_pkg::OP_LOAD, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (m_phase == i2cw_pkg::PH_ACK_POLL) begin
        sda = (ack_delay >= 0 && polls >= ack_delay) ? 1'b0 : 1'b1;
        polls++;
        send_tick(sda);
      end else begin
        send_tick(1'($urandom_range(1)));
      end
    end
  endtask

  // Ticks on a bus at rest change nothing
  task automatic test_idle_ticks();
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // Data byte without start on an idle bus, nack at the reset timeout
  task automatic test_no_start();
    run_byte(8'hA5, 1'b0, 1'b1, -1, 0);
  endtask

  // Address byte with bit 0 set, hold between bytes, then a stop
  task automatic test_address_byte();
    run_byte(8'hFF, 1'b1, 1'b0, 2, 0);
    send_tick(1'b0);
    send_tick(1'b1);
    run_byte(8'h00, 1'b0, 1'b1, 0, 0);
  endtask

  // Loads during a busy byte are dropped
  task automatic test_busy_load();
    run_byte(8'h5A, 1'b1, 1'b1, 1, 30);
  endtask

  // Start again from hold without a stop in between
  task automatic test_repeated_start();
    run_byte(8'h81, 1'b1, 1'b0, 0, 0);
    run_byte(8'h7F, 1'b1, 1'b1, 1, 0);
  endtask

  // Timeout register at zero, one and the maximum
  task automatic test_timeout_extremes();
    wait_drained();
    write_timeout(8'd0);
    run_byte(8'h3C, 1'b1, 1'b1, -1, 0);
    wait_drained();
    write_timeout(8'd1);
    run_byte(8'hC3, 1'b1, 1'b0, -1, 0);
    run_byte(8'h18, 1'b0, 1'b1, 0, 0);
    wait_drained();
    write_timeout(i2cw_pkg::WAIT_MAX);
    run_byte(8'h96, 1'b1, 1'b1, -1, 0);
    run_byte(8'h69, 1'b1, 1'b1, 254, 0);
  endtask

  // A random write transaction of one to four bytes, with stray ticks and loads
  task automatic rand_transfer();
    int   nbytes;
    int   ack_delay;
    logic first_mark;
    logic last_mark;
    nbytes = $urandom_range(1, 4);
    for (int k = 0; k < nbytes; k++) begin
      first_mark = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
      last_mark  = (k == nbytes - 1) ? ($urandom_range(5) != 0) : 1'b0;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: ack_delay = $urandom_range(0, 3);
        6, 7:             ack_delay = $urandom_range(0, int'(m_timeout) + 1);
        default:          ack_delay = -1;
      endcase
      run_byte(8'($urandom_range(255)), first_mark, last_mark, ack_delay, 4);
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) send_tick(1'($urandom_range(1)));
      end
    end
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input logic [7:0] timeout,
                           input int quota);
    int target;
    wait_drained();
    write_timeout(timeout);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    target = useful_items + quota;
    while (useful_items < target) rand_transfer();
  endtask

  // Random traffic under three stall patterns and timeouts
  task automatic test_random_traffic();
    int quota;
    quota = (ITEM_TARGET - useful_items) / 3;
    run_phase(22, 66, 8'($urandom_range(2, 8)), quota);
    run_phase(66, 22, 8'd1, quota);
    run_phase(0, 0, 8'($urandom_range(3, 40)), quota);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.op      = i2cw_pkg::OP_TICK;
    in_bus.data    = '0;
    in_bus.first   = 1'b0;
    in_bus.last    = 1'b0;
    in_bus.sda_in  = 1'b1;
    cfg_bus.valid  = 1'b0;
    cfg_bus.data   = '0;
    out_bus.ready  = 1'b0;
    errors         = 0;
    useful_items   = 0;
    cycles         = 0;
    src_idle_pct   = 0;
    sink_idle_pct  = 0;
    m_phase        = i2cw_pkg::PH_IDLE;
    m_shift        = '0;
    m_bit_idx      = '0;
    m_wait         = '0;
    m_stop         = 1'b0;
    m_scl          = 1'b1;
    m_sda          = 1'b1;
    m_timeout      = i2cw_pkg::ACK_TIMEOUT_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_ticks();
    test_no_start();
    test_address_byte();
    test_busy_load();
    test_repeated_start();
    test_timeout_extremes();
    test_random_traffic();

    in_bus.valid = 1'b0;
    wait_drained();
    repeat (5) @(negedge clk);
    if (errors == 0 && expected_levels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
